@@ design/keypad_datetime_entry_editor_defines.svh @@
// ----------------------------------------------------------------------------
// keypad_datetime_entry_editor_defines
// Assertion macros shared by the keypad date/time entry editor.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_DATETIME_ENTRY_EDITOR_DEFINES_SVH
`define KEYPAD_DATETIME_ENTRY_EDITOR_DEFINES_SVH

// same-cycle implication, checked on every clock edge outside reset
`define KDE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/kde_pkg.sv @@
// ----------------------------------------------------------------------------
// kde_pkg
// Types and constants of the keypad date/time entry editor.
// ----------------------------------------------------------------------------
package kde_pkg;

  localparam int NumDigits = 15;
  localparam logic [3:0] LastPos = 4'd14;

  // digit positions in the edit buffer
  localparam int PosHour    = 0;
  localparam int PosMinute  = 2;
  localparam int PosSecond  = 4;
  localparam int PosDay     = 6;
  localparam int PosMonth   = 8;
  localparam int PosYear    = 10;
  localparam int PosWeekday = 14;

  // range limits of the commit check
  localparam logic [6:0]  MaxHour    = 7'd23;
  localparam logic [6:0]  MaxMinSec  = 7'd59;
  localparam logic [6:0]  MaxDay     = 7'd31;
  localparam logic [6:0]  MaxMonth   = 7'd12;
  localparam logic [3:0]  MaxWeekday = 4'd6;
  localparam logic [13:0] MinYear    = 14'd2000;
  localparam logic [13:0] MaxYear    = 14'd2099;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_KEY  = 1'b1
  } req_t;

  typedef enum logic [3:0] {
    KEY_NINE  = 4'd9,
    KEY_PLUS  = 4'd10,
    KEY_MINUS = 4'd11,
    KEY_CLEAR = 4'd12,
    KEY_EQUAL = 4'd13
  } key_t;

  typedef enum logic [1:0] {
    ST_APPLIED   = 2'd0,
    ST_INVALID   = 2'd1,
    ST_COMMITTED = 2'd2,
    ST_IGNORED   = 2'd3
  } status_t;

  typedef logic [3:0] digit_t;
  typedef digit_t [NumDigits-1:0] digits_t;

  // one input item after the load value has been split into digits
  typedef struct packed {
    logic       req_type;
    logic [3:0] key_code;
    digits_t    digits;
  } stage_item_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  cursor;
    logic [6:0]  new_hour;
    logic [6:0]  new_minute;
    logic [6:0]  new_second;
    logic [6:0]  new_day;
    logic [6:0]  new_month;
    logic [13:0] new_year;
    logic [3:0]  new_weekday;
  } result_t;

endpackage

@@ design/kde_if.sv @@
// ----------------------------------------------------------------------------
// kde_if
// Valid/ready channels of the keypad date/time entry editor.
// ----------------------------------------------------------------------------
interface kde_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  key_code;
  logic [4:0]  cur_hour;
  logic [5:0]  cur_minute;
  logic [5:0]  cur_second;
  logic [4:0]  cur_day;
  logic [3:0]  cur_month;
  logic [11:0] cur_year;
  logic [2:0]  cur_weekday;

  modport source (
    output valid, req_type, key_code, cur_hour, cur_minute, cur_second,
           cur_day, cur_month, cur_year, cur_weekday,
    input  ready
  );
  modport sink (
    input  valid, req_type, key_code, cur_hour, cur_minute, cur_second,
           cur_day, cur_month, cur_year, cur_weekday,
    output ready
  );
endinterface

interface kde_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  cursor;
  logic [6:0]  new_hour;
  logic [6:0]  new_minute;
  logic [6:0]  new_second;
  logic [6:0]  new_day;
  logic [6:0]  new_month;
  logic [13:0] new_year;
  logic [3:0]  new_weekday;

  modport source (
    output valid, status, cursor, new_hour, new_minute, new_second,
           new_day, new_month, new_year, new_weekday,
    input  ready
  );
  modport sink (
    input  valid, status, cursor, new_hour, new_minute, new_second,
           new_day, new_month, new_year, new_weekday,
    output ready
  );
endinterface

@@ design/kde_load_split.sv @@
// ----------------------------------------------------------------------------
// kde_load_split
// Splits the current time fields into the fifteen decimal digits of the
// edit buffer.
// ----------------------------------------------------------------------------
module kde_load_split (
  input  logic [4:0]       cur_hour,
  input  logic [5:0]       cur_minute,
  input  logic [5:0]       cur_second,
  input  logic [4:0]       cur_day,
  input  logic [3:0]       cur_month,
  input  logic [11:0]      cur_year,
  input  logic [2:0]       cur_weekday,
  output kde_pkg::digits_t digits
);
  import kde_pkg::*;

  // reciprocal multiplies, exact for every 12-bit value
  function automatic logic [8:0] div10(input logic [11:0] v);
    logic [26:0] p;
    p = 27'(v) * 27'd3277;
    return p[23:15];
  endfunction

  function automatic logic [5:0] div100(input logic [11:0] v);
    logic [26:0] p;
    p = 27'(v) * 27'd1311;
    return p[22:17];
  endfunction

  function automatic logic [2:0] div1000(input logic [11:0] v);
    logic [26:0] p;
    p = 27'(v) * 27'd4195;
    return p[24:22];
  endfunction

  // v - 10*q, where q is v/10
  function automatic digit_t units(input logic [11:0] v, input logic [8:0] q);
    logic [11:0] t;
    t = v - 12'(q) * 12'd10;
    return t[3:0];
  endfunction

  function automatic logic [7:0] split_pair(input logic [11:0] v);
    logic [8:0] q;
    q = div10(v);
    return {q[3:0], units(v, q)};
  endfunction

  logic [7:0] hour_d, minute_d, second_d, day_d, month_d;
  logic [8:0] year_q1;
  logic [5:0] year_q2;
  logic [2:0] year_q3;

  always_comb begin
    hour_d   = split_pair(12'(cur_hour));
    minute_d = split_pair(12'(cur_minute));
    second_d = split_pair(12'(cur_second));
    day_d    = split_pair(12'(cur_day));
    month_d  = split_pair(12'(cur_month));
    year_q1  = div10(cur_year);
    year_q2  = div100(cur_year);
    year_q3  = div1000(cur_year);

    digits[PosHour]      = hour_d[7:4];
    digits[PosHour+1]    = hour_d[3:0];
    digits[PosMinute]    = minute_d[7:4];
    digits[PosMinute+1]  = minute_d[3:0];
    digits[PosSecond]    = second_d[7:4];
    digits[PosSecond+1]  = second_d[3:0];
    digits[PosDay]       = day_d[7:4];
    digits[PosDay+1]     = day_d[3:0];
    digits[PosMonth]     = month_d[7:4];
    digits[PosMonth+1]   = month_d[3:0];
    digits[PosYear]      = 4'(year_q3);
    digits[PosYear+1]    = units(12'(year_q2), 9'(year_q3));
    digits[PosYear+2]    = units(12'(year_q1), 9'(year_q2));
    digits[PosYear+3]    = units(cur_year, year_q1);
    digits[PosWeekday]   = 4'(cur_weekday);
  end

endmodule

@@ design/kde_edit_core.sv @@
// ----------------------------------------------------------------------------
// kde_edit_core
// Edit buffer, cursor and editing flag; applies one staged item per cycle
// while adv is high and registers its result.
// ----------------------------------------------------------------------------
module kde_edit_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  kde_pkg::stage_item_t item,
  output kde_pkg::result_t     result
);
  import kde_pkg::*;

  function automatic logic [6:0] pair_val(input digit_t hi, input digit_t lo);
    return 7'(hi) * 7'd10 + 7'(lo);
  endfunction

  digits_t     store;
  digits_t     store_next;
  logic [3:0]  cursor_pos;
  logic [3:0]  cursor_pos_next;
  logic        editing;
  logic        editing_next;
  result_t     result_next;
  logic [6:0]  hh, mi, ss, dd, mo;
  logic [13:0] yy;
  logic [3:0]  wd;
  logic        bad;

  always_comb begin
    store_next      = store;
    cursor_pos_next = cursor_pos;
    editing_next    = editing;
    result_next     = '0;
    result_next.status = ST_APPLIED;

    if (item.req_type == REQ_LOAD) begin
      store_next      = item.digits;
      cursor_pos_next = '0;
      editing_next    = 1'b1;
    end else if (editing) begin
      if (item.key_code <= KEY_NINE) begin
        store_next[cursor_pos] = item.key_code;
      end else begin
        case (item.key_code)
          KEY_PLUS: begin
            if (cursor_pos < LastPos) cursor_pos_next = cursor_pos + 4'd1;
          end
          KEY_MINUS: begin
            if (cursor_pos != '0) cursor_pos_next = cursor_pos - 4'd1;
          end
          KEY_CLEAR: begin
            store_next      = '0;
            cursor_pos_next = '0;
          end
          default: ;
        endcase
      end
    end

    hh = pair_val(store_next[PosHour],   store_next[PosHour+1]);
    mi = pair_val(store_next[PosMinute], store_next[PosMinute+1]);
    ss = pair_val(store_next[PosSecond], store_next[PosSecond+1]);
    dd = pair_val(store_next[PosDay],    store_next[PosDay+1]);
    mo = pair_val(store_next[PosMonth],  store_next[PosMonth+1]);
    yy = 14'(store_next[PosYear])   * 14'd1000
       + 14'(store_next[PosYear+1]) * 14'd100
       + 14'(store_next[PosYear+2]) * 14'd10
       + 14'(store_next[PosYear+3]);
    wd = store_next[PosWeekday];

    bad = (hh > MaxHour) || (mi > MaxMinSec) || (ss > MaxMinSec)
       || (dd == '0) || (dd > MaxDay) || (mo == '0) || (mo > MaxMonth)
       || (wd > MaxWeekday) || (yy < MinYear) || (yy > MaxYear);

    if (item.req_type == REQ_KEY && !editing) begin
      // buffer untouched, decoded fields stay zero
      result_next.status = ST_IGNORED;
    end else begin
      if (item.req_type == REQ_KEY && item.key_code == KEY_EQUAL) begin
        if (bad) begin
          result_next.status = ST_INVALID;
        end else begin
          result_next.status = ST_COMMITTED;
          editing_next       = 1'b0;
        end
      end
      result_next.new_hour    = hh;
      result_next.new_minute  = mi;
      result_next.new_second  = ss;
      result_next.new_day     = dd;
      result_next.new_month   = mo;
      result_next.new_year    = yy;
      result_next.new_weekday = wd;
    end
    result_next.cursor = cursor_pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_pos <= '0;
      editing    <= 1'b0;
    end else if (adv) begin
      cursor_pos <= cursor_pos_next;
      editing    <= editing_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      store  <= store_next;
      result <= result_next;
    end
  end

endmodule

@@ design/keypad_datetime_entry_editor.sv @@
// ----------------------------------------------------------------------------
// keypad_datetime_entry_editor
// Keypad time and date entry editor with a fifteen-digit edit buffer.
// ----------------------------------------------------------------------------
// Each item passes an input register and then a result register before its
// result shows at the output; a new item is taken in every cycle while
// results are drained; the throughput of one item per cycle is set by the
// single edit stage, which updates buffer, cursor and editing flag and
// decodes and range-checks the buffer in the same cycle. Load items are
// split into decimal digits ahead of the input register.
`include "keypad_datetime_entry_editor_defines.svh"

module keypad_datetime_entry_editor (
  input  logic clk,
  input  logic rst,
  kde_in_if.sink    item_in,
  kde_out_if.source item_out
);
  import kde_pkg::*;

  digits_t     load_digits;
  stage_item_t stage;
  logic        stage_valid;
  logic        out_valid;
  logic        adv;
  result_t     result;

  kde_load_split u_load_split (
    .cur_hour    (item_in.cur_hour),
    .cur_minute  (item_in.cur_minute),
    .cur_second  (item_in.cur_second),
    .cur_day     (item_in.cur_day),
    .cur_month   (item_in.cur_month),
    .cur_year    (item_in.cur_year),
    .cur_weekday (item_in.cur_weekday),
    .digits      (load_digits)
  );

  // staged item moves on whenever the result register is free or drains
  assign adv           = stage_valid && (!out_valid || item_out.ready);
  assign item_in.ready = !stage_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (item_in.valid && item_in.ready) stage_valid <= 1'b1;
      else if (adv)                       stage_valid <= 1'b0;
      if (adv)                 out_valid <= 1'b1;
      else if (item_out.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      stage.req_type <= item_in.req_type;
      stage.key_code <= item_in.key_code;
      stage.digits   <= load_digits;
    end
  end

  kde_edit_core u_edit_core (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .item   (stage),
    .result (result)
  );

  assign item_out.valid       = out_valid;
  assign item_out.status      = result.status;
  assign item_out.cursor      = result.cursor;
  assign item_out.new_hour    = result.new_hour;
  assign item_out.new_minute  = result.new_minute;
  assign item_out.new_second  = result.new_second;
  assign item_out.new_day     = result.new_day;
  assign item_out.new_month   = result.new_month;
  assign item_out.new_year    = result.new_year;
  assign item_out.new_weekday = result.new_weekday;

  `KDE_ASSERT_IMPLIES(a_cursor_range, item_out.valid, item_out.cursor <= LastPos, "cursor out of range")
  `KDE_ASSERT_IMPLIES(a_commit_in_range, item_out.valid && item_out.status == ST_COMMITTED, item_out.new_hour <= MaxHour && item_out.new_month != '0 && item_out.new_month <= MaxMonth && item_out.new_year >= MinYear && item_out.new_year <= MaxYear && item_out.new_weekday <= MaxWeekday, "commit with out-of-range value")
  `KDE_ASSERT_IMPLIES(a_ignored_zero, item_out.valid && item_out.status == ST_IGNORED, item_out.new_hour == '0 && item_out.new_year == '0 && item_out.new_weekday == '0, "ignored item shows decoded values")
  `KDE_ASSERT_NEXT(a_stage_drains, stage_valid && !out_valid, out_valid, "staged item not moved to result")

endmodule
